### hw/rtl/cdad_pkg.sv
package cdad_pkg;

  localparam int unsigned YearW      = 14;
  localparam int unsigned MonthW     = 4;
  localparam int unsigned DayW       = 5;
  localparam int unsigned OffsetPortW = 12;
  localparam int unsigned OffsetBitsDefault = 12;
  localparam int unsigned RemW       = 9;   // year mod 400 fits here
  localparam int unsigned StepW      = 3;

  localparam logic [YearW-1:0]  YearMin  = YearW'(1);
  localparam logic [YearW-1:0]  YearMax  = YearW'(9999);
  localparam logic [MonthW-1:0] MonthJan = MonthW'(1);
  localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonthDec = MonthW'(12);
  localparam logic [RemW-1:0]   RemLast  = RemW'(399);
  localparam logic [StepW-1:0]  StepTop  = StepW'(4);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StReduce = 6'b000010,
    StClamp  = 6'b000100,
    StAdd    = 6'b001000,
    StSub    = 6'b010000,
    StDone   = 6'b100000
  } state_e;

  // 400 shifted left by the step number, for the restoring mod-400 reduction.
  function automatic logic [YearW-1:0] reduce_step(input logic [StepW-1:0] k);
    logic [YearW-1:0] v;
    unique case (k)
      3'd4:    v = YearW'(6400);
      3'd3:    v = YearW'(3200);
      3'd2:    v = YearW'(1600);
      3'd1:    v = YearW'(800);
      default: v = YearW'(400);
    endcase
    return v;
  endfunction

  // Month length from the year's remainder mod 400 and the month.
  function automatic logic [DayW-1:0] days_in(input logic [RemW-1:0] rem,
                                              input logic [MonthW-1:0] m);
    logic leap;
    logic [DayW-1:0] v;
    leap = (rem[1:0] == 2'd0) && (rem != RemW'(100)) && (rem != RemW'(200)) &&
           (rem != RemW'(300));
    unique case (m)
      MonthFeb:               v = leap ? DayW'(29) : DayW'(28);
      4'd4, 4'd6, 4'd9, 4'd11: v = DayW'(30);
      default:                v = DayW'(31);
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/calendar_date_add_days.sv
// The input transfer starts a restoring reduction of the start year mod 400, then a
// day clamp that applies the offset, then carries or borrows one month at a time
// (at most about 135 months for a 12-bit offset); a start year outside 1..9999
// gives its result in the cycle after the transfer. One item at a time: the input
// is ready again only after the result transfer.
// Reset: rst_ni clears the sequencer to idle and drops the result valid.

module calendar_date_add_days
  import cdad_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OffsetBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   func_i,
  input  logic [YearW-1:0]       start_year_i,
  input  logic [MonthW-1:0]      start_month_i,
  input  logic [DayW-1:0]        start_day_i,
  input  logic [OffsetPortW-1:0] offset_days_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [YearW-1:0]       result_year_o,
  output logic [MonthW-1:0]      result_month_o,
  output logic [DayW-1:0]        result_day_o,
  output logic                   out_of_range_o
);

  // Only the offset bits below OFFSET_BITS count, and the port carries at most
  // OffsetPortW of them.
  localparam int unsigned OffW = (OFFSET_BITS < OffsetPortW) ? OFFSET_BITS : OffsetPortW;
  // Running day count: a sign bit plus room for 31 + the largest offset.
  localparam int unsigned DW = ((OffW > DayW) ? OffW : DayW) + 2;

  state_e state_q, state_d;

  // The original date is kept so that an out-of-range result can echo it.
  logic [YearW-1:0]  in_year_q;
  logic [MonthW-1:0] in_month_q;
  logic [DayW-1:0]   in_day_q;
  logic              func_q;
  logic [OffW-1:0]   off_q;

  logic [YearW-1:0]  year_q, year_d;
  logic [MonthW-1:0] month_q, month_d;
  logic signed [DW-1:0] day_q, day_d;
  // Holds the year during the reduction and afterwards the year mod 400,
  // which is stepped along with the year so the leap test stays cheap.
  logic [YearW-1:0]  rem_q, rem_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              bad_q, bad_d;

  logic              accept;
  logic [RemW-1:0]   rem9;
  logic [DayW-1:0]   dim_cur;
  logic [MonthW-1:0] month_prev;
  logic [YearW-1:0]  year_prev;
  logic [RemW-1:0]   rem_prev;
  logic              wrap_back;
  logic [DayW-1:0]   dim_prev;
  logic signed [DW-1:0] day_clamp;
  logic signed [DW-1:0] off_ext;
  logic signed [DW-1:0] sum_opnd;
  logic signed [DW-1:0] sum_res;
  logic [YearW-1:0]  step_val;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);
  assign rem9       = rem_q[RemW-1:0];
  assign dim_cur    = days_in(rem9, month_q);
  assign step_val   = reduce_step(step_q);
  assign off_ext    = $signed({{(DW-OffW){1'b0}}, off_q});

  // Candidate previous month for the borrow loop, with the December wrap.
  assign wrap_back  = (month_q == MonthJan);
  assign month_prev = wrap_back ? MonthDec : month_q - MonthW'(1);
  assign year_prev  = wrap_back ? year_q - YearW'(1) : year_q;
  assign rem_prev   = !wrap_back ? rem9 : ((rem9 == '0) ? RemLast : rem9 - RemW'(1));
  assign dim_prev   = days_in(rem_prev, month_prev);

  // Day clamped to the starting month.
  always_comb begin
    day_clamp = $signed({{(DW-DayW){1'b0}}, in_day_q});
    if (in_day_q == '0) begin
      day_clamp = $signed(DW'(1));
    end else if (in_day_q > dim_cur) begin
      day_clamp = $signed({{(DW-DayW){1'b0}}, dim_cur});
    end
  end

  // The shared day adder: it applies the offset, then carries or borrows a
  // whole month per cycle.
  always_comb begin
    sum_opnd = off_ext;
    unique case (state_q)
      StAdd:   sum_opnd = -$signed({{(DW-DayW){1'b0}}, dim_cur});
      StSub:   sum_opnd = $signed({{(DW-DayW){1'b0}}, dim_prev});
      StClamp: sum_opnd = func_q ? -off_ext : off_ext;
      default: sum_opnd = off_ext;
    endcase
  end

  assign sum_res = ((state_q == StAdd) || (state_q == StSub)) ? day_q + sum_opnd
                                                              : day_clamp + sum_opnd;

  always_comb begin
    state_d = state_q;
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    rem_d   = rem_q;
    step_d  = step_q;
    bad_d   = bad_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          year_d  = start_year_i;
          rem_d   = start_year_i;
          step_d  = StepTop;
          bad_d   = 1'b0;
          if (start_month_i == '0) begin
            month_d = MonthJan;
          end else if (start_month_i > MonthDec) begin
            month_d = MonthDec;
          end else begin
            month_d = start_month_i;
          end
          if ((start_year_i < YearMin) || (start_year_i > YearMax)) begin
            bad_d   = 1'b1;
            state_d = StDone;
          end else begin
            state_d = StReduce;
          end
        end
      end
      StReduce: begin
        // Restoring reduction of the year modulo 400, one multiple per cycle.
        if (rem_q >= step_val) begin
          rem_d = rem_q - step_val;
        end
        step_d = step_q - StepW'(1);
        if (step_q == '0) begin
          state_d = StClamp;
        end
      end
      StClamp: begin
        day_d   = sum_res;
        state_d = func_q ? StSub : StAdd;
      end
      StAdd: begin
        if (day_q > $signed({{(DW-DayW){1'b0}}, dim_cur})) begin
          day_d = sum_res;
          if (month_q == MonthDec) begin
            month_d = MonthJan;
            year_d  = year_q + YearW'(1);
            rem_d   = (rem9 == RemLast) ? '0 : rem_q + YearW'(1);
            if (year_q == YearMax) begin
              bad_d   = 1'b1;
              state_d = StDone;
            end
          end else begin
            month_d = month_q + MonthW'(1);
          end
        end else begin
          state_d = StDone;
        end
      end
      StSub: begin
        if (day_q < $signed(DW'(1))) begin
          if (wrap_back && (year_q == YearMin)) begin
            bad_d   = 1'b1;
            state_d = StDone;
          end else begin
            month_d = month_prev;
            year_d  = year_prev;
            rem_d   = {{(YearW-RemW){1'b0}}, rem_prev};
            day_d   = sum_res;
          end
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers carry no reset; they are loaded on the input transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_year_q  <= start_year_i;
      in_month_q <= start_month_i;
      in_day_q   <= start_day_i;
      func_q     <= func_i;
      off_q      <= offset_days_i[OffW-1:0];
    end
    year_q  <= year_d;
    month_q <= month_d;
    day_q   <= day_d;
    rem_q   <= rem_d;
    step_q  <= step_d;
    bad_q   <= bad_d;
  end

  // The result is held in the working registers until its transfer; an
  // out-of-range result shows the starting date exactly as given.
  assign out_valid_o    = (state_q == StDone);
  assign out_of_range_o = bad_q;
  assign result_year_o  = bad_q ? in_year_q  : year_q;
  assign result_month_o = bad_q ? in_month_q : month_q;
  assign result_day_o   = bad_q ? in_day_q   : day_q[DayW-1:0];

endmodule
